// ===== rtl/core/rrts_pkg.sv =====
// Shared constants, opcodes and sequencer states for the round-robin task scheduler.
package rrts_pkg;

   localparam int MAX_TASKS_DEFAULT = 16;
   localparam int TASK_W            = 4;
   localparam int TIME_W            = 64;
   localparam int TICKS_W           = 32;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [1:0] {
      OP_SCHEDULE = 2'd0,
      OP_SLEEP    = 2'd1,
      OP_ADD      = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PARK,
      ST_ADD,
      ST_ADD_TAIL,
      ST_SCAN,
      ST_ROT_RD,
      ST_ROT_WR,
      ST_REPLY
   } state_type;

endpackage

// ===== rtl/core/rrts_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
module rrts_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/core/round_robin_task_scheduler.sv =====
// Round-robin task scheduler top level: sequencer around ready, sleep and wake-time RAMs.
//
//   channel   ports                                         handshake
//   request   req_opcode, req_now_time, req_sleep_ticks     start / busy
//   response  rsp_running_task, rsp_new_task, rsp_status    rsp_valid strobe
//
// One request in flight at a time; busy stays high from accept through the response strobe.
// Schedule runs the wake scan, then rotates the ready head unless no task is ready.
// The wake scan streams one sleep entry per cycle through the sleep and wake-time RAMs.
// Sleep parks the running task first; add may fix the tail; an unused opcode only replies.
// Reset is synchronous; the RAMs need no clearing since no entry is read before it is written.
// The response is a one-cycle strobe that cannot be stalled.
module round_robin_task_scheduler import rrts_pkg::*; #(
   parameter int MAX_TASKS = MAX_TASKS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [TIME_W-1:0]  req_now_time,
   input  logic [TICKS_W-1:0] req_sleep_ticks,
   output logic               rsp_valid,
   output logic [TASK_W-1:0]  rsp_running_task,
   output logic [TASK_W-1:0]  rsp_new_task,
   output logic               rsp_status
);

   localparam int IW = $clog2(MAX_TASKS);
   localparam int CW = $clog2(MAX_TASKS + 1);

   state_type state_ff, state_in;

   logic [IW-1:0]      head_ff, head_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      slp_cnt_ff, slp_cnt_in;
   logic [IW-1:0]      cur_ff, cur_in;
   logic [CW-1:0]      next_id_ff, next_id_in;
   logic [CW-1:0]      scan_idx_ff, scan_idx_in;
   logic [CW-1:0]      kept_ff, kept_in;
   logic               s1_vld_ff, s1_vld_in;
   logic               s2_vld_ff, s2_vld_in;

   logic [TIME_W-1:0]  now_ff, now_in;
   logic [TICKS_W-1:0] ticks_ff, ticks_in;
   logic [IW-1:0]      new_id_ff, new_id_in;
   logic               status_ff, status_in;
   logic [IW-1:0]      tail_ff, tail_in;
   logic [IW-1:0]      s2_id_ff, s2_id_in;

   logic               ring_we, ring_re;
   logic [IW-1:0]      ring_waddr, ring_raddr, ring_wdata, ring_rdata;
   logic               slp_we, slp_re;
   logic [IW-1:0]      slp_waddr, slp_raddr, slp_wdata, slp_rdata;
   logic               wake_we, wake_re;
   logic [IW-1:0]      wake_waddr, wake_raddr;
   logic [TIME_W-1:0]  wake_wdata, wake_rdata;

   logic               ring_live, ring_room, slp_room, add_full;
   logic               issue, scan_done, wake_hit;
   logic [IW-1:0]      pos_cnt, pos_last, head_next;

   function automatic logic [IW-1:0] ring_pos(input logic [IW-1:0] base,
                                              input logic [CW-1:0] k);
      logic [CW:0] sum;
      sum = (CW+1)'(base) + (CW+1)'(k);
      if (sum >= (CW+1)'(MAX_TASKS)) begin
         sum = sum - (CW+1)'(MAX_TASKS);
      end
      return sum[IW-1:0];
   endfunction

   rrts_ram #(.WIDTH(IW), .DEPTH(MAX_TASKS)) u_ready_ram (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (ring_wdata),
      .rd_en   (ring_re),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

   rrts_ram #(.WIDTH(IW), .DEPTH(MAX_TASKS)) u_sleep_ram (
      .clock   (clock),
      .wr_en   (slp_we),
      .wr_addr (slp_waddr),
      .wr_data (slp_wdata),
      .rd_en   (slp_re),
      .rd_addr (slp_raddr),
      .rd_data (slp_rdata)
   );

   rrts_ram #(.WIDTH(TIME_W), .DEPTH(MAX_TASKS)) u_wake_ram (
      .clock   (clock),
      .wr_en   (wake_we),
      .wr_addr (wake_waddr),
      .wr_data (wake_wdata),
      .rd_en   (wake_re),
      .rd_addr (wake_raddr),
      .rd_data (wake_rdata)
   );

   // The running task, when not idle, is always the ready tail.
   assign ring_live = (cur_ff != '0) && (count_ff != '0);
   assign ring_room = count_ff < CW'(MAX_TASKS);
   assign slp_room  = slp_cnt_ff < CW'(MAX_TASKS);
   assign add_full  = (next_id_ff >= CW'(MAX_TASKS)) || !ring_room;
   assign pos_cnt   = ring_pos(head_ff, count_ff);
   assign pos_last  = ring_pos(head_ff, count_ff - CW'(1));
   assign head_next = (head_ff == IW'(MAX_TASKS - 1)) ? '0 : head_ff + IW'(1);
   assign issue     = scan_idx_ff < slp_cnt_ff;
   assign scan_done = !issue && !s1_vld_ff && !s2_vld_ff;
   assign wake_hit  = wake_rdata <= now_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_opcode)
                  OP_SCHEDULE: state_in = ST_SCAN;
                  OP_SLEEP:    state_in = ST_PARK;
                  OP_ADD:      state_in = ST_ADD;
                  default:     state_in = ST_REPLY;
               endcase
            end
         end
         ST_PARK:     state_in = ST_SCAN;
         ST_ADD:      state_in = (!add_full && ring_live) ? ST_ADD_TAIL : ST_REPLY;
         ST_ADD_TAIL: state_in = ST_REPLY;
         ST_SCAN:     state_in = scan_done ? ST_ROT_RD : ST_SCAN;
         ST_ROT_RD:   state_in = (count_ff == '0) ? ST_REPLY : ST_ROT_WR;
         ST_ROT_WR:   state_in = ST_REPLY;
         ST_REPLY:    state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy             = state_ff != ST_IDLE;
      rsp_valid        = state_ff == ST_REPLY;
      rsp_running_task = TASK_W'(cur_ff);
      rsp_new_task     = TASK_W'(new_id_ff);
      rsp_status       = status_ff;
   end

   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      slp_cnt_in  = slp_cnt_ff;
      cur_in      = cur_ff;
      next_id_in  = next_id_ff;
      scan_idx_in = '0;
      kept_in     = '0;
      s1_vld_in   = 1'b0;
      s2_vld_in   = 1'b0;
      now_in      = now_ff;
      ticks_in    = ticks_ff;
      new_id_in   = new_id_ff;
      status_in   = status_ff;
      tail_in     = tail_ff;
      s2_id_in    = s2_id_ff;
      ring_we     = 1'b0;
      ring_waddr  = pos_cnt;
      ring_wdata  = '0;
      ring_re     = 1'b0;
      ring_raddr  = head_ff;
      slp_we      = 1'b0;
      slp_waddr   = '0;
      slp_wdata   = '0;
      slp_re      = 1'b0;
      slp_raddr   = '0;
      wake_we     = 1'b0;
      wake_waddr  = cur_ff;
      wake_wdata  = '0;
      wake_re     = 1'b0;
      wake_raddr  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               now_in    = req_now_time;
               ticks_in  = req_sleep_ticks;
               new_id_in = '0;
               status_in = STATUS_OK;
            end
         end
         ST_PARK: begin
            // Drop the running task off the ready tail and park it.
            if (ring_live) begin
               count_in   = count_ff - CW'(1);
               wake_we    = 1'b1;
               wake_wdata = now_ff + TIME_W'(ticks_ff);
               if (slp_room) begin
                  slp_we     = 1'b1;
                  slp_waddr  = slp_cnt_ff[IW-1:0];
                  slp_wdata  = cur_ff;
                  slp_cnt_in = slp_cnt_ff + CW'(1);
               end
            end
         end
         ST_ADD: begin
            if (add_full) begin
               status_in = STATUS_FULL;
            end else begin
               new_id_in  = next_id_ff[IW-1:0];
               next_id_in = next_id_ff + CW'(1);
               count_in   = count_ff + CW'(1);
               ring_we    = 1'b1;
               // Running task moves one slot out; the new id takes its old slot next cycle.
               ring_wdata = ring_live ? cur_ff : next_id_ff[IW-1:0];
               tail_in    = pos_last;
            end
         end
         ST_ADD_TAIL: begin
            ring_we    = 1'b1;
            ring_waddr = tail_ff;
            ring_wdata = new_id_ff;
         end
         ST_SCAN: begin
            scan_idx_in = scan_idx_ff;
            kept_in     = kept_ff;
            if (issue) begin
               slp_re      = 1'b1;
               slp_raddr   = scan_idx_ff[IW-1:0];
               scan_idx_in = scan_idx_ff + CW'(1);
               s1_vld_in   = 1'b1;
            end
            if (s1_vld_ff) begin
               wake_re    = 1'b1;
               wake_raddr = slp_rdata;
               s2_vld_in  = 1'b1;
               s2_id_in   = slp_rdata;
            end
            // Compaction write trails the read pointer, so the two never collide.
            if (s2_vld_ff) begin
               if (wake_hit) begin
                  if (ring_room) begin
                     ring_we    = 1'b1;
                     ring_wdata = s2_id_ff;
                     count_in   = count_ff + CW'(1);
                  end
               end else begin
                  slp_we    = 1'b1;
                  slp_waddr = kept_ff[IW-1:0];
                  slp_wdata = s2_id_ff;
                  kept_in   = kept_ff + CW'(1);
               end
            end
            if (scan_done) begin
               slp_cnt_in = kept_ff;
            end
         end
         ST_ROT_RD: begin
            if (count_ff == '0) begin
               cur_in = '0;
            end else begin
               ring_re = 1'b1;
            end
         end
         ST_ROT_WR: begin
            ring_we    = 1'b1;
            ring_wdata = ring_rdata;
            head_in    = head_next;
            cur_in     = ring_rdata;
         end
         ST_REPLY: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_ff     <= '0;
         count_ff    <= '0;
         slp_cnt_ff  <= '0;
         cur_ff      <= '0;
         next_id_ff  <= CW'(1);
         scan_idx_ff <= '0;
         kept_ff     <= '0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         count_ff    <= count_in;
         slp_cnt_ff  <= slp_cnt_in;
         cur_ff      <= cur_in;
         next_id_ff  <= next_id_in;
         scan_idx_ff <= scan_idx_in;
         kept_ff     <= kept_in;
         s1_vld_ff   <= s1_vld_in;
         s2_vld_ff   <= s2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff    <= now_in;
      ticks_ff  <= ticks_in;
      new_id_ff <= new_id_in;
      status_ff <= status_in;
      tail_ff   <= tail_in;
      s2_id_ff  <= s2_id_in;
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe lasted more than one cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CW'(MAX_TASKS)) && (slp_cnt_ff <= CW'(MAX_TASKS)))
      else $error("queue count exceeds table size");

   a_running_in_ring: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && cur_ff != '0) |-> (count_ff != '0))
      else $error("running task not held in ready queue");

   a_scan_pipe: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff || s2_vld_ff) |-> (state_ff == ST_SCAN))
      else $error("wake scan pipeline active outside scan");

endmodule

// ===== sim/round_robin_task_scheduler_tb.sv =====
// Self-checking testbench for the round-robin task scheduler with sleep queue.
module round_robin_task_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rrts_pkg::*;

   localparam int NTASK = MAX_TASKS_DEFAULT;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 625;
   localparam int QUIET_FROM = 300;
   localparam int QUIET_TO = 450;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      logic [1:0]         op;
      logic [TIME_W-1:0]  now;
      logic [TICKS_W-1:0] ticks;
      bit                 drain;
   } sched_req;

   typedef struct {
      logic [TASK_W-1:0] running;
      logic [TASK_W-1:0] new_id;
      logic              status;
   } sched_rsp;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_opcode = '0;
   logic [TIME_W-1:0]  req_now_time = '0;
   logic [TICKS_W-1:0] req_sleep_ticks = '0;
   logic               rsp_valid;
   logic [TASK_W-1:0]  rsp_running_task;
   logic [TASK_W-1:0]  rsp_new_task;
   logic               rsp_status;

   sched_req pending[$];
   sched_rsp outcome_q[$];
   sched_req offered;
   int       n_taken = 0;
   int       fails = 0;
   int       cycles = 0;

   // scheduler shadow state
   int                rq_slot[NTASK];
   int                rq_head = 0;
   int                rq_len = 0;
   int                sleepers[NTASK];
   int                sleeper_cnt = 0;
   logic [TIME_W-1:0] wake_at[NTASK];
   int                running = 0;
   int                id_next = 1;

   round_robin_task_scheduler u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_now_time     (req_now_time),
      .req_sleep_ticks  (req_sleep_ticks),
      .rsp_valid        (rsp_valid),
      .rsp_running_task (rsp_running_task),
      .rsp_new_task     (rsp_new_task),
      .rsp_status       (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void push_ready(input int id);
      if (rq_len < NTASK) begin
         rq_slot[(rq_head + rq_len) % NTASK] = id;
         rq_len++;
      end
   endfunction

   // Wake due sleepers in sleep order, then rotate the ready head to the tail.
   function automatic void run_schedule(input logic [TIME_W-1:0] now);
      int kept;
      int id;
      kept = 0;
      for (int i = 0; i < sleeper_cnt; i++) begin
         id = sleepers[i];
         if (wake_at[id] <= now) begin
            push_ready(id);
         end else begin
            sleepers[kept] = id;
            kept++;
         end
      end
      sleeper_cnt = kept;
      if (rq_len == 0) begin
         running = 0;
      end else begin
         id = rq_slot[rq_head];
         rq_slot[(rq_head + rq_len) % NTASK] = id;
         rq_head = (rq_head + 1) % NTASK;
         running = id;
      end
   endfunction

   function automatic sched_rsp predict_outcome(input sched_req rq);
      sched_rsp o;
      int       id;
      int       tail;
      int       fresh;
      o.new_id = '0;
      o.status = STATUS_OK;
      case (rq.op)
         OP_SCHEDULE: run_schedule(rq.now);
         OP_SLEEP: begin
            // park the running task, which is the ready tail
            if (running != 0 && rq_len > 0) begin
               id = rq_slot[(rq_head + rq_len - 1) % NTASK];
               rq_len--;
               wake_at[id] = rq.now + {32'd0, rq.ticks};
               if (sleeper_cnt < NTASK) begin
                  sleepers[sleeper_cnt] = id;
                  sleeper_cnt++;
               end
            end
            run_schedule(rq.now);
         end
         OP_ADD: begin
            if (id_next >= NTASK || rq_len >= NTASK) begin
               o.status = STATUS_FULL;
            end else begin
               fresh = id_next;
               o.new_id = 4'(fresh);
               id_next++;
               // slot the new task in just ahead of the running one
               if (running != 0 && rq_len > 0) begin
                  tail = (rq_head + rq_len - 1) % NTASK;
                  id = rq_slot[tail];
                  rq_slot[tail] = fresh;
                  rq_slot[(rq_head + rq_len) % NTASK] = id;
                  rq_len++;
               end else begin
                  push_ready(fresh);
               end
            end
         end
         default: ;
      endcase
      o.running = 4'(running);
      return o;
   endfunction

   function automatic void queue_item(input logic [1:0] op, input logic [TIME_W-1:0] now,
                                      input logic [TICKS_W-1:0] ticks, input bit drain);
      sched_req it;
      it.op = op;
      it.now = now;
      it.ticks = ticks;
      it.drain = drain;
      pending.push_back(it);
   endfunction

   always @(posedge clock) begin : drive
      logic idle_now;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            outcome_q.push_back(predict_outcome(offered));
            n_taken++;
         end
         // hold the word while busy, else offer the next one
         if (!start || !busy) begin
            idle_now = (n_taken < QUIET_FROM || n_taken >= QUIET_TO) &&
                       ($urandom_range(0, 99) < 19);
            if (pending.size() > 0 && !idle_now &&
                !(pending[0].drain && outcome_q.size() > 0)) begin
               offered = pending.pop_front();
               req_opcode <= offered.op;
               req_now_time <= offered.now;
               req_sleep_ticks <= offered.ticks;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch
      sched_rsp want;
      if (!reset && rsp_valid) begin
         if (outcome_q.size() == 0) begin
            $display("%0t: unexpected word: running %0d new %0d status %0d", $time,
                     rsp_running_task, rsp_new_task, rsp_status);
            fails++;
         end else begin
            want = outcome_q.pop_front();
            if (rsp_running_task !== want.running) begin
               $display("%0t: running_task expected %0d got %0d", $time, want.running,
                        rsp_running_task);
               fails++;
            end
            if (rsp_new_task !== want.new_id) begin
               $display("%0t: new_task expected %0d got %0d", $time, want.new_id,
                        rsp_new_task);
               fails++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d got %0d", $time, want.status, rsp_status);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached", $time);
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      logic [TIME_W-1:0]  tl;
      logic [TICKS_W-1:0] ticks;
      logic [1:0]         op;
      int                 roll;
      bit                 drain;

      // directed: idle cases, insertion, wake edge, wrap, full table
      queue_item(OP_SCHEDULE, 0, 0, 1'b0);
      queue_item(OP_SLEEP, 10, 5, 1'b0);
      queue_item(OP_UNUSED, 20, 0, 1'b0);
      queue_item(OP_ADD, 30, 0, 1'b0);
      queue_item(OP_ADD, 40, 0, 1'b0);
      queue_item(OP_SCHEDULE, 50, 0, 1'b0);
      queue_item(OP_ADD, 60, 0, 1'b0);
      queue_item(OP_SLEEP, 100, 0, 1'b0);
      queue_item(OP_SLEEP, 64'hFFFF_FFFF_FFFF_FFF0, 32'hFFFF_FFFF, 1'b0);
      queue_item(OP_SCHEDULE, 64'h1_0000_0000, 0, 1'b0);
      queue_item(OP_UNUSED, '1, '1, 1'b0);
      for (int i = 0; i < 12; i++) queue_item(OP_ADD, 200 + i, 0, 1'b0);
      queue_item(OP_ADD, 300, 0, 1'b0);
      queue_item(OP_SCHEDULE, '1, 0, 1'b0);

      // random: mostly a forward-running timeline, some noise
      tl = 64'h1_0000_0000;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         drain = (n % 150 == 0);
         roll = $urandom_range(0, 99);
         if (n % 60 == 59) begin
            // wake every sleeper, including ones parked far in the future
            queue_item(OP_SCHEDULE, '1, $urandom, drain);
         end else if (roll < 6) begin
            queue_item(2'($urandom_range(0, 3)), {$urandom, $urandom}, $urandom, drain);
         end else begin
            tl += $urandom_range(0, 16);
            roll = $urandom_range(0, 99);
            if (roll < 45) op = OP_SCHEDULE;
            else if (roll < 82) op = OP_SLEEP;
            else if (roll < 97) op = OP_ADD;
            else op = OP_UNUSED;
            roll = $urandom_range(0, 99);
            if (roll < 10) ticks = '0;
            else if (roll < 90) ticks = $urandom_range(1, 60);
            else ticks = $urandom;
            queue_item(op, tl, ticks, drain);
         end
      end

      while (pending.size() > 0 || start) @(posedge clock);
      for (int w = 0; w < DRAIN_LIMIT && outcome_q.size() > 0; w++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (outcome_q.size() != 0) begin
         $display("%0t: %0d words never arrived", $time, outcome_q.size());
         fails++;
      end
      if (fails == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

endmodule
